>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the ULEB128 delta address stream.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition always implies a consequence at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst, cond, cons, msg) \
  `ASSERT_CLK(lbl, clk, rst, (cond) |-> (cons), msg)

`endif

>>> src/ulebd_pkg.sv
// Package with types and constants of the ULEB128 delta address stream.
`default_nettype none

package ulebd_pkg;

  localparam logic [7:0] PAYLOAD_MASK = 8'h7F;
  localparam logic [7:0] CONT_BIT     = 8'h80;
  localparam logic [6:0] SHIFT_STEP   = 7'd7;

  typedef enum logic [1:0] {
    KIND_ADDRESS  = 2'd0,
    KIND_END      = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] addr;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [63:0] running;
    logic [63:0] partial;
    logic [6:0]  shift;
    logic        stopped;
  } dec_state_t;

  typedef struct packed {
    dec_state_t  state_next;
    logic [1:0]  n_results;
    result_t     res0;
    result_t     res1;
  } dec_out_t;

  typedef struct packed {
    logic not_empty;
    logic space2;
  } fifo_status_t;

endpackage

`default_nettype wire

>>> src/ulebd_decode.sv
// Combinational decode of one byte against the current decoder state.
`default_nettype none

module ulebd_decode (
  input  wire logic [7:0]             data_byte,
  input  wire logic                   last_byte,
  input  wire logic [63:0]            base,
  input  wire ulebd_pkg::dec_state_t  state,
  output ulebd_pkg::dec_out_t         dec
);
  import ulebd_pkg::*;

  dec_state_t  st;
  result_t     dec_res;
  result_t     end_res;
  logic        has_dec;
  logic [63:0] slice;
  logic [63:0] partial_new;

  always_comb begin
    st          = state;
    has_dec     = 1'b0;
    dec_res     = '0;
    end_res     = '0;
    slice       = {56'd0, data_byte & PAYLOAD_MASK} << state.shift[5:0];
    partial_new = state.partial | slice;

    if (!state.stopped) begin
      if (state.shift == 7'd0 && data_byte == 8'd0) begin
        st.stopped = 1'b1;
      end else if (state.shift[6]) begin
        // Shift has reached 64 or more: the value cannot fit.
        has_dec      = 1'b1;
        dec_res.kind = KIND_OVERFLOW;
        st.partial   = '0;
        st.shift     = '0;
        st.stopped   = 1'b1;
      end else begin
        st.partial = partial_new;
        st.shift   = state.shift + SHIFT_STEP;
        if ((data_byte & CONT_BIT) == 8'd0) begin
          has_dec      = 1'b1;
          st.running   = state.running + partial_new;
          dec_res.kind = KIND_ADDRESS;
          dec_res.addr = state.running + partial_new;
          st.partial   = '0;
          st.shift     = '0;
        end
      end
    end

    end_res.kind = KIND_END;
    end_res.last = 1'b1;
    dec_res.last = !last_byte;

    if (last_byte) begin
      st.running = base;
      st.partial = '0;
      st.shift   = '0;
      st.stopped = 1'b0;
    end

    dec.state_next = st;
    dec.n_results  = {1'b0, has_dec} + {1'b0, last_byte};
    dec.res0       = has_dec ? dec_res : end_res;
    dec.res1       = end_res;
  end

endmodule

`default_nettype wire

>>> src/ulebd_result_fifo.sv
// Register queue of result transactions, taking up to two results per cycle.
`default_nettype none

module ulebd_result_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [1:0]              push_n,
  input  wire ulebd_pkg::result_t      push0,
  input  wire ulebd_pkg::result_t      push1,
  input  wire logic                    pop,
  output ulebd_pkg::result_t           head,
  output ulebd_pkg::fifo_status_t      status
);
  import ulebd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  result_t            mem [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   wptr_next;
  logic [PTR_W-1:0]   rptr;
  logic [PTR_W-1:0]   wp1;
  logic [PTR_W-1:0]   wp2;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wp1 = ptr_inc(wptr);
  assign wp2 = ptr_inc(wp1);

  always_comb begin
    unique case (push_n)
      2'd1:    wptr_next = wp1;
      2'd2:    wptr_next = wp2;
      default: wptr_next = wptr;
    endcase
    count_next = count + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wptr] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wp1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr_next;
      count <= count_next;
      if (pop) begin
        rptr <= ptr_inc(rptr);
      end
    end
  end

  assign head             = mem[rptr];
  assign status.not_empty = (count != '0);
  assign status.space2    = (count <= CNT_W'(DEPTH - 2));

endmodule

`default_nettype wire

>>> src/uleb128_delta_address_stream.sv
// Top level of the ULEB128 delta address stream decoder.
// Usage:
//   The input channel (in_valid, in_stall, data_byte, last_byte) carries one
//   byte of a ULEB128 delta list per transaction. The output channel
//   (out_valid, out_stall, result_kind, function_address, last_of_run)
//   carries one result per transaction: a decoded address, an end marker or
//   an overflow error. One byte gives zero, one or two results, and
//   last_of_run marks the final result of a byte.
//   A byte that is taken sits in the input register until the queue has room
//   for two more results; it is then decoded and queued, and its first result
//   is offered once it is queued.
//   Throughput is one byte per cycle while the queue has room. The output
//   side moves one result per cycle while out_stall is low, so a byte that
//   gives two results occupies the output for both of them in turn.
//   A cfg_write with cfg_data sets the base address and restarts decoding from it;
//   the user must write only while the block is idle; the block does not enforce it.
//   Reset clears the queue, the input register and the decoder state, and
//   sets the base address to zero.
//   When the receiver stalls, queued results hold still; in_stall is raised
//   while a held byte waits for room for two more results in the queue.
`default_nettype none

module uleb128_delta_address_stream #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic [63:0]      function_address,
  output logic             last_of_run
);
  import ulebd_pkg::*;

  `include "assert_macros.svh"

  // Configuration and decoder state.
  logic [63:0]  base;
  dec_state_t   state;

  // Input register: holds one byte transaction until it is decoded.
  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;

  dec_out_t     dec;
  fifo_status_t fifo_status;
  result_t      head;
  logic         advance;
  logic         in_take;
  logic         out_take;

  // The held byte moves on only when the queue has room for both of its
  // possible results.
  assign advance  = s1_valid && fifo_status.space2;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  ulebd_decode u_decode (
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .base      (base),
    .state     (state),
    .dec       (dec)
  );

  // A base write restarts the decoder; the user must send it only while idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= '0;
      state <= '0;
    end else if (cfg_write) begin
      base          <= cfg_data;
      state.running <= cfg_data;
      state.partial <= '0;
      state.shift   <= '0;
      state.stopped <= 1'b0;
    end else if (advance) begin
      state <= dec.state_next;
    end
  end

  ulebd_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (advance ? dec.n_results : 2'd0),
    .push0  (dec.res0),
    .push1  (dec.res1),
    .pop    (out_take),
    .head   (head),
    .status (fifo_status)
  );

  assign out_valid        = fifo_status.not_empty;
  assign out_take         = out_valid && !out_stall;
  assign result_kind      = head.kind;
  assign function_address = head.addr;
  assign last_of_run      = head.last;

  // A new byte is only taken when the input register is free this cycle.
  `ASSERT_IMPLIES(a_in_reg_free, clk, rst, in_take, !s1_valid || advance,
    "byte accepted while the input register stays occupied")
  // The end marker always closes the results of its byte.
  `ASSERT_IMPLIES(a_end_is_last, clk, rst, out_valid && result_kind == KIND_END,
    last_of_run, "end marker not flagged as final result")
  // Only address results carry an address.
  `ASSERT_IMPLIES(a_addr_zero, clk, rst, out_valid && result_kind != KIND_ADDRESS,
    function_address == 64'd0, "non-address result carries an address")

endmodule

`default_nettype wire

>>> dv/uleb128_delta_address_stream_test.sv
// Self-checking testbench for the ULEB128 delta address stream decoder.
`timescale 1ns / 100ps

module uleb128_delta_address_stream_test;
  import ulebd_pkg::*;

  // The run is cut off here if it stalls; a correct run needs a small fraction of this.
  localparam int CYCLE_LIMIT = 400000;
  // The receiver holds off for this many cycles once enough bytes have gone in.
  localparam int HOLD_CYCLES = 120;
  localparam int HOLD_AT = 150;
  // Cycles allowed after the last expected result, so bytes with no result can finish.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES = 440;

  // One byte of the encoded list together with its end-of-region flag.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [63:0] cfg_data = 64'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [63:0] function_address;
  logic        last_of_run;

  // Bytes waiting to be sent, and results the decoder still owes us.
  stream_byte_t byte_q[$];
  result_t      decoded_q[$];

  // Our own copy of the decoder state and of the base address register.
  logic [63:0] dec_base = 64'd0;
  logic [63:0] dec_running = 64'd0;
  logic [63:0] dec_partial = 64'd0;
  logic [6:0]  dec_shift = 7'd0;
  logic        dec_stopped = 1'b0;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_overflows = 0;
  int n_bases = 1;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int backpressure_cycles = 0;
  int cycle_count = 0;

  uleb128_delta_address_stream u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .function_address (function_address),
    .last_of_run      (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A base write or the end of a region puts the decoder back at the base address.
  task automatic rewind_decoder();
    dec_running = dec_base;
    dec_partial = 64'd0;
    dec_shift = 7'd0;
    dec_stopped = 1'b0;
  endtask

  // Decodes one accepted byte and queues the zero, one or two results it causes.
  task automatic decode_byte(input logic [7:0] b, input logic l);
    result_t res[2];
    int n;
    n = 0;
    if (!dec_stopped) begin
      if (dec_shift == 7'd0 && b == 8'h00) begin
        // A zero byte where a new value would start terminates the list.
        dec_stopped = 1'b1;
      end else if (dec_shift > 7'd63) begin
        // Ten continuation bytes already consumed: the delta cannot fit in 64 bits.
        res[n].kind = KIND_OVERFLOW;
        res[n].addr = 64'd0;
        res[n].last = 1'b0;
        n++;
        n_overflows++;
        dec_partial = 64'd0;
        dec_shift = 7'd0;
        dec_stopped = 1'b1;
      end else begin
        // At shift 63 only bit 0 of the slice survives; the 64-bit context drops the rest.
        dec_partial = dec_partial | ({56'd0, b & PAYLOAD_MASK} << dec_shift);
        dec_shift = dec_shift + SHIFT_STEP;
        if ((b & CONT_BIT) == 8'h00) begin
          dec_running = dec_running + dec_partial;
          res[n].kind = KIND_ADDRESS;
          res[n].addr = dec_running;
          res[n].last = 1'b0;
          n++;
          dec_partial = 64'd0;
          dec_shift = 7'd0;
        end
      end
    end
    if (l) begin
      // The last byte of a region always closes with an end marker, even when stopped.
      res[n].kind = KIND_END;
      res[n].addr = 64'd0;
      res[n].last = 1'b0;
      n++;
      rewind_decoder();
    end
    if (n > 0) begin
      res[n - 1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      decoded_q.push_back(res[i]);
    end
  endtask

  // Driver: keeps a byte on the input until it is taken, then offers the next one
  // unless the sender decides to idle this cycle.
  always @(posedge clk) begin : drive_bytes
    stream_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(data_byte, last_byte);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          nxt = byte_q.pop_front();
          in_valid <= 1'b1;
          data_byte <= nxt.data;
          last_byte <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off. It fires once, early in the run, and counts its own cycles
  // so that the result queue fills up and the decoder has to push back on its input.
  always @(posedge clk) begin : long_hold
    if (!rst) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        if (in_stall) begin
          backpressure_cycles++;
        end
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end
  end

  // Monitor: every result that moves is compared with the oldest expected one.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result: kind %0d address %h last %b",
                     result_kind, function_address, last_of_run);
          end
        end else begin
          want = decoded_q.pop_front();
          if (result_kind !== want.kind || function_address !== want.addr ||
              last_of_run !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("Result %0d mismatch: expected kind %0d address %h last %b, ",
                     n_results, want.kind, want.addr, want.last);
              $display("got kind %0d address %h last %b",
                       result_kind, function_address, last_of_run);
            end
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results still expected",
               cycle_count, decoded_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic l, input bit counts);
    stream_byte_t s;
    s.data = b;
    s.last = l;
    byte_q.push_back(s);
    if (counts) begin
      n_queued++;
    end
  endtask

  // Builds one region of the stream. Most regions are well-formed lists of deltas with
  // random payloads; the rest are raw noise, truncated values or oversized values.
  task automatic queue_region();
    int nvals;
    int len;
    int pick;
    logic [7:0] b;
    bit overflowed;
    overflowed = 1'b0;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(12, 1)) begin
        queue_byte(8'($urandom_range(255)), $urandom_range(15) == 0, 1'b1);
      end
      return;
    end
    nvals = $urandom_range(6, 1);
    for (int v = 0; v < nvals && !overflowed; v++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        len = $urandom_range(2, 1);
      end else if (pick < 85) begin
        len = $urandom_range(5, 3);
      end else if (pick < 95) begin
        len = $urandom_range(10, 6);
      end else begin
        len = $urandom_range(13, 11);
      end
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(127));
        if (i < len - 1 || len > 10) begin
          b = b | CONT_BIT;
        end else if (len == 1 && b == 8'h00) begin
          // A lone zero here would end the list instead of adding a delta.
          b = 8'h01;
        end
        // Bytes after the overflow byte are ignored by the decoder.
        queue_byte(b, 1'b0, i <= 10);
      end
      overflowed = (len > 10);
    end
    pick = $urandom_range(99);
    if (overflowed) begin
      repeat ($urandom_range(2)) begin
        queue_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      end
      queue_byte(8'($urandom_range(255)), 1'b1, 1'b1);
    end else if (pick < 45) begin
      byte_q[$].last = 1'b1;
    end else if (pick < 70) begin
      // Explicit end of list, some ignored trailing bytes, then the end of the region.
      queue_byte(8'h00, 1'b0, 1'b1);
      repeat ($urandom_range(3)) begin
        queue_byte(8'($urandom_range(255)), 1'b0, 1'b0);
      end
      queue_byte(8'($urandom_range(255)), 1'b1, 1'b1);
    end else if (pick < 85) begin
      // The region ends in the middle of a value, which must be dropped.
      repeat ($urandom_range(3, 1)) begin
        queue_byte(8'($urandom_range(255)) | CONT_BIT, 1'b0, 1'b1);
      end
      queue_byte(8'($urandom_range(255)) | CONT_BIT, 1'b1, 1'b1);
    end
  endtask

  // Waits until every byte is taken and every result has come, then lets a byte that
  // causes no result work its way through before anything else changes.
  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || decoded_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The write also restarts decoding from the new base.
  task automatic write_base(input logic [63:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    dec_base = value;
    rewind_decoder();
    n_bases++;
  endtask

  task automatic run_phase(input logic [63:0] base, input int snd_pct, input int rcv_pct);
    int start;
    write_base(base);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    start = n_queued;
    while (n_queued - start < PHASE_BYTES) begin
      queue_region();
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, decoded against the reset base of zero.
    // A single byte value on the last byte gives an address and an end marker.
    queue_byte(8'h7F, 1'b1, 1'b1);
    // A zero byte inside a value just completes it.
    queue_byte(8'h80, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    // A zero byte at the start of a value ends the list; the next byte is ignored
    // except for its end marker.
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'hAA, 1'b1, 1'b1);
    // Ten-byte value whose last byte lands at shift 63: all 64 bits set.
    repeat (9) queue_byte(8'hFF, 1'b0, 1'b1);
    queue_byte(8'h7F, 1'b0, 1'b1);
    // Shift overflow followed at once by the end of the region.
    repeat (10) queue_byte(8'h80, 1'b0, 1'b1);
    queue_byte(8'h05, 1'b1, 1'b1);
    wait_drained();

    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 29, 48);
    run_phase({$urandom, $urandom}, 48, 29);
    run_phase(64'd0, 0, 0);

    $display("Decoded %0d input bytes into %0d results (%0d overflow errors),",
             n_accepted, n_results, n_overflows);
    $display("over %0d base addresses; input held back %0d cycles in the long hold-off.",
             n_bases, backpressure_cycles);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, decoded_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
